[hdl/hbtw_pkg.sv]
`default_nettype none

package hbtw_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int SLOT_DEPTH_DEF = 32;
    localparam int CONNECTIONS    = 256;

    localparam int ID_W   = 8;
    localparam int CNT_W  = 8;
    localparam int KIND_W = 3;
    localparam int DLY_W  = 4;
    localparam int OFF_W  = 4;

    localparam logic [OFF_W-1:0] EXPIRE_RESET = 4'd10;
    localparam logic [CNT_W-1:0] COUNT_MAX    = 8'd255;

    localparam logic [KIND_W-1:0] K_ADD_OK  = 3'd0;
    localparam logic [KIND_W-1:0] K_ADD_REJ = 3'd1;
    localparam logic [KIND_W-1:0] K_ALIVE   = 3'd2;
    localparam logic [KIND_W-1:0] K_KILLED  = 3'd3;
    localparam logic [KIND_W-1:0] K_EMPTY   = 3'd4;

    typedef struct packed {
        logic add_rd;
        logic add_wr;
        logic tick_rd;
        logic ent_rd;
        logic cnt_rd;
        logic upd;
        logic empty;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic fill_zero;
        logic last_ent;
    } t_sts;

endpackage

`default_nettype wire

[hdl/hbtw_ctrl.sv]
`default_nettype none

module hbtw_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    input  wire             i_operation,
    output logic            o_ready,
    input  hbtw_pkg::t_sts  i_sts,
    output hbtw_pkg::t_cmd  o_cmd
);
    import hbtw_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADD    = 3'd1;
    localparam logic [2:0] S_TFILL  = 3'd2;
    localparam logic [2:0] S_TEMPTY = 3'd3;
    localparam logic [2:0] S_TENT   = 3'd4;
    localparam logic [2:0] S_TCNT   = 3'd5;
    localparam logic [2:0] S_TUPD   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_operation) begin
                        o_cmd.tick_rd = 1'b1;
                        n_state       = S_TFILL;
                    end else begin
                        o_cmd.add_rd = 1'b1;
                        n_state      = S_ADD;
                    end
                end
            end
            S_ADD: begin
                if (i_sts.out_free) begin
                    o_cmd.add_wr = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_TFILL: begin
                n_state = i_sts.fill_zero ? S_TEMPTY : S_TENT;
            end
            S_TEMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.empty = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_TENT: begin
                o_cmd.ent_rd = 1'b1;
                n_state      = S_TCNT;
            end
            S_TCNT: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = S_TUPD;
            end
            S_TUPD: begin
                if (i_sts.out_free) begin
                    o_cmd.upd = 1'b1;
                    n_state   = i_sts.last_ent ? S_IDLE : S_TENT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/hbtw_dp.sv]
`default_nettype none

module hbtw_dp #(
    parameter int SLOTS      = hbtw_pkg::SLOTS_DEF,
    parameter int SLOT_DEPTH = hbtw_pkg::SLOT_DEPTH_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  hbtw_pkg::t_cmd                i_cmd,
    output hbtw_pkg::t_sts                o_sts,
    input  wire [hbtw_pkg::ID_W-1:0]      i_conn_id,
    input  wire [hbtw_pkg::DLY_W-1:0]     i_delay,
    input  wire                           i_cfg_wr_en,
    input  wire [hbtw_pkg::OFF_W-1:0]     i_cfg_wr_data,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic [hbtw_pkg::KIND_W-1:0]   o_kind,
    output logic [hbtw_pkg::ID_W-1:0]     o_conn_id_res,
    output logic [hbtw_pkg::CNT_W-1:0]    o_use_count,
    output logic                          o_last
);
    import hbtw_pkg::*;

    localparam int SW     = $clog2(SLOTS);
    localparam int FW     = $clog2(SLOT_DEPTH + 1);
    localparam int DW     = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int EDEPTH = SLOTS << DW;
    localparam int SUM_W  = OFF_W + 1;
    localparam int SUM_N  = 1 << SUM_W;

    logic [OFF_W-1:0]  r_expire;
    logic [SW-1:0]     r_cur;
    logic [SW-1:0]     r_slot;
    logic [ID_W-1:0]   r_id;
    logic [DW-1:0]     r_idx;

    logic [FW-1:0]     r_fill_mem [SLOTS];
    logic [SLOTS-1:0]  r_fill_vld;
    logic [FW-1:0]     r_fill_rd;
    logic              r_fill_rv;

    logic [CNT_W-1:0]        r_cnt_mem [CONNECTIONS];
    logic [CONNECTIONS-1:0]  r_cnt_vld;
    logic [CNT_W-1:0]        r_cnt_rd;
    logic                    r_cnt_rv;

    logic [ID_W-1:0]   r_ent_mem [EDEPTH];
    logic [ID_W-1:0]   r_ent_rd;

    logic              r_out_valid;
    logic [KIND_W-1:0] r_kind;
    logic [ID_W-1:0]   r_id_res;
    logic [CNT_W-1:0]  r_count;
    logic              r_last;

    logic [SW-1:0]     w_mod_tab [SUM_N];
    logic [SUM_W-1:0]  w_sum;
    logic [SW:0]       w_slot_sum;
    logic [SW-1:0]     w_slot;
    logic [SW-1:0]     w_cur_next;
    logic [FW-1:0]     w_fill;
    logic [CNT_W-1:0]  w_cnt;
    logic [CNT_W-1:0]  w_dec;
    logic              w_add_ok;
    logic              w_out_free;
    logic              w_last_ent;

    for (genvar g = 0; g < SUM_N; g++) begin : g_mod
        assign w_mod_tab[g] = SW'(g % SLOTS);
    end

    assign w_sum      = SUM_W'(i_delay) + SUM_W'(r_expire);
    assign w_slot_sum = {1'b0, r_cur} + {1'b0, w_mod_tab[w_sum]};
    assign w_slot     = (w_slot_sum >= (SW+1)'(SLOTS)) ?
                        SW'(w_slot_sum - (SW+1)'(SLOTS)) : SW'(w_slot_sum);
    assign w_cur_next = (r_cur == SW'(SLOTS - 1)) ? '0 : r_cur + 1'b1;

    assign w_fill     = r_fill_rv ? r_fill_rd : '0;
    assign w_cnt      = r_cnt_rv ? r_cnt_rd : '0;
    assign w_dec      = (w_cnt == '0) ? '0 : w_cnt - 1'b1;
    assign w_add_ok   = (w_fill < FW'(SLOT_DEPTH)) && (w_cnt != COUNT_MAX);
    assign w_out_free = !r_out_valid || i_ready;
    assign w_last_ent = ((FW'(r_idx) + 1'b1) == w_fill);

    assign o_sts.out_free  = w_out_free;
    assign o_sts.fill_zero = (w_fill == '0);
    assign o_sts.last_ent  = w_last_ent;

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_rd) begin
            r_fill_rd <= r_fill_mem[w_slot];
        end else if (i_cmd.tick_rd) begin
            r_fill_rd <= r_fill_mem[r_cur];
        end
        if (i_cmd.add_wr && w_add_ok) begin
            r_fill_mem[r_slot] <= w_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_rd) begin
            r_cnt_rd <= r_cnt_mem[i_conn_id];
        end else if (i_cmd.cnt_rd) begin
            r_cnt_rd <= r_cnt_mem[r_ent_rd];
        end
        if (i_cmd.add_wr && w_add_ok) begin
            r_cnt_mem[r_id] <= w_cnt + 1'b1;
        end else if (i_cmd.upd) begin
            r_cnt_mem[r_ent_rd] <= w_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ent_rd) begin
            r_ent_rd <= r_ent_mem[{r_slot, r_idx}];
        end
        if (i_cmd.add_wr && w_add_ok) begin
            r_ent_mem[{r_slot, DW'(w_fill)}] <= r_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_rd) begin
            r_slot <= w_slot;
            r_id   <= i_conn_id;
        end else if (i_cmd.tick_rd) begin
            r_slot <= r_cur;
        end
        if (i_cmd.add_rd) begin
            r_fill_rv <= r_fill_vld[w_slot];
            r_cnt_rv  <= r_cnt_vld[i_conn_id];
        end else if (i_cmd.tick_rd) begin
            r_fill_rv <= r_fill_vld[r_cur];
        end else if (i_cmd.cnt_rd) begin
            r_cnt_rv <= r_cnt_vld[r_ent_rd];
        end
        if (i_cmd.tick_rd) begin
            r_idx <= '0;
        end else if (i_cmd.upd) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expire   <= EXPIRE_RESET;
            r_cur      <= '0;
            r_fill_vld <= '0;
            r_cnt_vld  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_expire <= i_cfg_wr_data;
            end
            if (i_cmd.add_wr && w_add_ok) begin
                r_fill_vld[r_slot] <= 1'b1;
                r_cnt_vld[r_id]    <= 1'b1;
            end
            if (i_cmd.upd) begin
                r_cnt_vld[r_ent_rd] <= 1'b1;
                if (w_last_ent) begin
                    r_fill_vld[r_slot] <= 1'b0;
                    r_cur              <= w_cur_next;
                end
            end
            if (i_cmd.empty) begin
                r_cur <= w_cur_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.add_wr || i_cmd.upd || i_cmd.empty) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_wr) begin
            r_kind   <= w_add_ok ? K_ADD_OK : K_ADD_REJ;
            r_id_res <= r_id;
            r_count  <= w_add_ok ? w_cnt + 1'b1 : w_cnt;
            r_last   <= 1'b1;
        end else if (i_cmd.upd) begin
            r_kind   <= (w_dec == '0) ? K_KILLED : K_ALIVE;
            r_id_res <= r_ent_rd;
            r_count  <= w_dec;
            r_last   <= w_last_ent;
        end else if (i_cmd.empty) begin
            r_kind   <= K_EMPTY;
            r_id_res <= '0;
            r_count  <= '0;
            r_last   <= 1'b1;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_kind;
    assign o_conn_id_res = r_id_res;
    assign o_use_count   = r_count;
    assign o_last        = r_last;

endmodule

`default_nettype wire

[hdl/heartbeat_timing_wheel_top.sv]
// An add item is accepted in the idle state and its result enters the output register
// from the add state. A tick on an empty slot passes through a fill read and yields one
// empty result; on a slot with entries, each entry passes through an entry read,
// a use-count read and a count write-back. Any step that loads a result waits while
// the output register still holds an item that has not been taken. Reset is synchronous
// and clears fills and use counts through valid flags; items are taken straight after.
`default_nettype none

module heartbeat_timing_wheel_top #(
    parameter int SLOTS      = hbtw_pkg::SLOTS_DEF,
    parameter int SLOT_DEPTH = hbtw_pkg::SLOT_DEPTH_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire                           i_operation,
    input  wire [hbtw_pkg::ID_W-1:0]      i_conn_id,
    input  wire [hbtw_pkg::DLY_W-1:0]     i_delay,
    input  wire                           i_cfg_wr_en,
    input  wire [hbtw_pkg::OFF_W-1:0]     i_cfg_wr_data,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic [hbtw_pkg::KIND_W-1:0]   o_kind,
    output logic [hbtw_pkg::ID_W-1:0]     o_conn_id_res,
    output logic [hbtw_pkg::CNT_W-1:0]    o_use_count,
    output logic                          o_last
);
    import hbtw_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    hbtw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_ready     (o_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    hbtw_dp #(
        .SLOTS      (SLOTS),
        .SLOT_DEPTH (SLOT_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_conn_id     (i_conn_id),
        .i_delay       (i_delay),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_conn_id_res (o_conn_id_res),
        .o_use_count   (o_use_count),
        .o_last        (o_last)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("Block still ready after taking an item.");

    a_result_from_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.add_wr || w_cmd.upd || w_cmd.empty))
        else $error("Result appeared without a producing command.");

    a_single_result_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == K_ADD_OK || o_kind == K_ADD_REJ || o_kind == K_EMPTY))
        |-> o_last)
        else $error("Single-result item not marked as last.");

endmodule

`default_nettype wire
